// ----- hw/rtl/glin_pkg.sv -----
// glin_pkg: shared widths, register indexes, status codes and constant
// functions for the gas sensor ppm linearizer.
// No dependencies.
package glin_pkg;

  localparam int V_W       = 13;
  localparam int PPM_W     = 17;
  localparam int RES_W     = 24;
  localparam int ST_W      = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 24;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOAD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_A = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RES_C = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PPM_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PPM_B = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PPM_C = 3'd7;

  // result status
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_ZERO  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  localparam logic [RES_W-1:0] RES_MAX = 24'hFFFFFF;

  // integer square root, bit-pair method (elaboration only)
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] t;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    t = x;
    for (int i = 0; i < 32; i++) begin
      if (t >= r + b) begin
        t = t - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q30 factor 2^(2^(j-16)), built by the same truncating root chain
  function automatic logic [30:0] exp_root(input int j);
    logic [63:0] c;
    c = 64'd2 << 30;
    for (int k = 15; k >= j; k--) begin
      c = isqrt64(c << 30);
    end
    return c[30:0];
  endfunction

endpackage

// ----- hw/rtl/glin_if.sv -----
// glin_if: valid/ready channels for sensor samples and results.
// Depends on glin_pkg.
interface glin_in_if;
  import glin_pkg::*;
  logic           valid;
  logic           ready;
  logic [V_W-1:0] voltage_mv;
  modport source(output valid, output voltage_mv, input ready);
  modport sink(input valid, input voltage_mv, output ready);
endinterface

interface glin_out_if;
  import glin_pkg::*;
  logic             valid;
  logic             ready;
  logic [PPM_W-1:0] concentration_ppm;
  logic [RES_W-1:0] resistance_kohm_q8;
  logic [ST_W-1:0]  status;
  modport source(output valid, output concentration_ppm, output resistance_kohm_q8,
                 output status, input ready);
  modport sink(input valid, input concentration_ppm, input resistance_kohm_q8,
               input status, output ready);
endinterface

// ----- hw/rtl/glin_div.sv -----
// glin_div: pipelined restoring unsigned divider, one quotient bit per stage,
// with a saturation flag when the quotient does not fit. No dependencies.
module glin_div #(
  parameter int NW = 54,
  parameter int DW = 33,
  parameter int QW = 24,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] quo,
  output logic          sat,
  output logic [SW-1:0] out_side
);
  localparam int W = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [NW-1:0] rem_r  [0:QW];
  logic [DW-1:0] den_r  [0:QW];
  logic [QW-1:0] q_r    [0:QW];
  logic          sat_r  [0:QW];
  logic [SW-1:0] side_r [0:QW];
  logic          vld_r  [0:QW];

  logic [W-1:0] num_w;
  logic [W-1:0] lim_w;
  assign num_w = W'(num);
  assign lim_w = W'(den) << QW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= num;
      den_r[0]  <= den;
      q_r[0]    <= '0;
      sat_r[0]  <= (num_w >= lim_w);
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_st
    logic [W-1:0] rem_w;
    logic [W-1:0] dsh_w;
    logic [W-1:0] dif_w;
    logic         ge;
    assign rem_w = W'(rem_r[s-1]);
    assign dsh_w = W'(den_r[s-1]) << (QW - s);
    assign ge    = (rem_w >= dsh_w);
    assign dif_w = rem_w - dsh_w;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s]  <= ge ? dif_w[NW-1:0] : rem_r[s-1];
        den_r[s]  <= den_r[s-1];
        q_r[s]    <= q_r[s-1] | (ge ? (QW'(1) << (QW - s)) : '0);
        sat_r[s]  <= sat_r[s-1];
        side_r[s] <= side_r[s-1];
      end
    end
  end

  assign out_vld  = vld_r[QW];
  assign quo      = q_r[QW];
  assign sat      = sat_r[QW];
  assign out_side = side_r[QW];

endmodule

// ----- hw/rtl/gas_sensor_ppm_linearizer_top.sv -----
// Gas sensor linearizer top: 87 register stages from the input register to the
// result register, throughput one transaction per cycle while no result waits.
// Depth is set by the two bit-per-stage dividers and the two 16-step
// squaring/root-product chains (31x31 multiplies: two per log stage, one per exp stage).
// The whole pipeline advances together; it holds only while a result waits.
// Reset (rst_n, synchronous) clears valid bits and loads the default config.
module gas_sensor_ppm_linearizer_top #(
  parameter int SUPPLY_MV  = 5000,
  parameter int CAL_POINTS = 3
) (
  input  logic                          clk,
  input  logic                          rst_n,
  glin_in_if.sink                       in_ch,
  glin_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [glin_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [glin_pkg::CFG_DW-1:0]    cfg_wdata
);
  import glin_pkg::*;

  // number of usable calibration points (three registers exist)
  localparam int NP     = (CAL_POINTS < 2) ? 2 : ((CAL_POINTS > 3) ? 3 : CAL_POINTS);
  // supply times worst-case quantized gain (milli)
  localparam int TOP_W  = $clog2(SUPPLY_MV * 99526 + 1);
  localparam int VK_W   = 23;
  localparam int NUM_W  = 17 + TOP_W + 8;
  localparam int DEN_W  = 33;
  localparam int LOG_W  = 21;
  localparam int M_W    = 31;
  localparam logic signed [24:0] E_HI = 25'sd1114112;   // 17.0 in Q16
  localparam logic signed [24:0] E_LO = -25'sd589824;   // -9.0 in Q16
  localparam logic [24:0] Q8_LIM = 25'd25599975;        // 99999.9 in Q8

  typedef struct packed {
    logic [M_W-1:0]   xi;
    logic [M_W-1:0]   xj;
    logic [LOG_W-1:0] li;
    logic [LOG_W-1:0] lj;
    logic [RES_W-1:0] ri;
    logic [RES_W-1:0] rj;
    logic [RES_W-1:0] res;
    logic             zero;
  } lg_t;

  typedef struct packed {
    logic [LOG_W-1:0] li;
    logic             neg;
    logic             flat;
    logic [RES_W-1:0] res;
    logic             zero;
  } side2_t;

  typedef struct packed {
    logic [M_W-1:0]   m;
    logic [15:0]      f;
    logic [4:0]       npl9;
    logic             hi;
    logic             lo;
    logic [RES_W-1:0] res;
    logic             zero;
  } ex_t;

  localparam int S2_W = $bits(side2_t);

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [6:0]       gain_r;
  logic [6:0]       load_r;
  logic [RES_W-1:0] res_a_r, res_b_r, res_c_r;
  logic [PPM_W-1:0] ppm_a_r, ppm_b_r, ppm_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= 7'd1;
      load_r  <= 7'd100;
      res_a_r <= 24'd29269;
      res_b_r <= 24'd10292;
      res_c_r <= 24'd3014;
      ppm_a_r <= 17'd50;
      ppm_b_r <= 17'd100;
      ppm_c_r <= 17'd300;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_GAIN:  gain_r  <= cfg_wdata[6:0];
        CFG_LOAD:  load_r  <= cfg_wdata[6:0];
        CFG_RES_A: res_a_r <= cfg_wdata;
        CFG_RES_B: res_b_r <= cfg_wdata;
        CFG_RES_C: res_c_r <= cfg_wdata;
        CFG_PPM_A: ppm_a_r <= cfg_wdata[PPM_W-1:0];
        CFG_PPM_B: ppm_b_r <= cfg_wdata[PPM_W-1:0];
        CFG_PPM_C: ppm_c_r <= cfg_wdata[PPM_W-1:0];
        default: ;
      endcase
    end
  end

  // Digipot quantization, two free-running register steps. Steps are
  // floor(x/100), done as x*5243 >> 19 (exact for x below 12900).
  logic [6:0]  g_cl, l_cl;
  logic [13:0] gx, lx;
  logic [26:0] gprod, lprod;
  logic [6:0]  gsteps_r;
  logic [7:0]  lsteps_r;
  logic [16:0] gain_milli_r, load_ohm_r;

  assign g_cl  = (gain_r == 7'd0) ? 7'd1 : ((gain_r > 7'd100) ? 7'd100 : gain_r);
  assign l_cl  = (load_r > 7'd100) ? 7'd100 : load_r;
  assign gx    = 14'(g_cl - 7'd1) << 7;
  assign lx    = (14'(l_cl) << 7) + 14'd99;
  assign gprod = 27'(gx) * 27'(5243);
  assign lprod = 27'(lx) * 27'(5243);

  always_ff @(posedge clk) begin
    gsteps_r     <= gprod[25:19];
    lsteps_r     <= lprod[26:19];
    gain_milli_r <= 17'd1120 + 17'(gsteps_r) * 17'd781;
    load_ohm_r   <= 17'(lsteps_r) * 17'd781 + 17'd120;
  end

  // ---------------------------------------------------------------------
  // pipeline control: everything moves unless a result is left untaken
  // ---------------------------------------------------------------------
  logic en;
  logic out_vld_r;
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // front: sample, scale to mV*1000, subtract from supply*gain
  logic             v1_vld_r, v2_vld_r, v3_vld_r;
  logic [V_W-1:0]   v1_r, v2_r, v3_r;
  logic [VK_W-1:0]  vk2_r;
  logic             zero2_r, zero3_r;
  logic [TOP_W-1:0] top_w, diff3_r;

  assign top_w = TOP_W'(gain_milli_r) * TOP_W'(SUPPLY_MV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_vld_r <= 1'b0;
      v2_vld_r <= 1'b0;
      v3_vld_r <= 1'b0;
    end else if (en) begin
      v1_vld_r <= in_ch.valid;
      v2_vld_r <= v1_vld_r;
      v3_vld_r <= v2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r    <= in_ch.voltage_mv;
      v2_r    <= v1_r;
      vk2_r   <= VK_W'(v1_r) * VK_W'(1000);
      zero2_r <= (v1_r == '0);
      v3_r    <= v2_r;
      zero3_r <= zero2_r;
      // at or above supply*gain the resistance clamps to zero
      diff3_r <= (top_w > TOP_W'(vk2_r)) ? (top_w - TOP_W'(vk2_r)) : '0;
    end
  end

  // R = load_ohm * diff * 256 / (1e6 * v)
  logic [NUM_W-1:0] num1_w;
  logic [DEN_W-1:0] den1_w;
  logic             d1_vld, d1_sat, d1_zero;
  logic [RES_W-1:0] d1_q;

  assign num1_w = (NUM_W'(load_ohm_r) * NUM_W'(diff3_r)) << 8;
  assign den1_w = DEN_W'(v3_r) * DEN_W'(1000000);

  glin_div #(.NW(NUM_W), .DW(DEN_W), .QW(RES_W), .SW(1)) u_div_res (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (v3_vld_r),
    .num      (num1_w),
    .den      (den1_w),
    .in_side  (zero3_r),
    .out_vld  (d1_vld),
    .quo      (d1_q),
    .sat      (d1_sat),
    .out_side (d1_zero)
  );

  // ---------------------------------------------------------------------
  // segment choice: first bracketing segment, else nearest end segment
  // ---------------------------------------------------------------------
  function automatic logic brk(input logic [RES_W-1:0] r, input logic [RES_W-1:0] a,
                               input logic [RES_W-1:0] b);
    return (r > a && r <= b) || (r <= a && r > b);
  endfunction

  logic [RES_W-1:0] r_w, last_w, d0_w, d1_w;
  logic             f0_w, f1_w, seg_w;
  logic             sg_vld_r, sg_zero_r, sg_seg_r;
  logic [RES_W-1:0] sg_res_r;

  assign r_w    = d1_sat ? RES_MAX : d1_q;
  assign last_w = (NP > 2) ? res_c_r : res_b_r;
  assign f0_w   = brk(r_w, res_a_r, res_b_r);
  assign f1_w   = (NP > 2) && brk(r_w, res_b_r, res_c_r);
  assign d0_w   = (r_w >= res_a_r) ? (r_w - res_a_r) : (res_a_r - r_w);
  assign d1_w   = (r_w >= last_w) ? (r_w - last_w) : (last_w - r_w);
  assign seg_w  = f0_w ? 1'b0 : (f1_w ? 1'b1 : ((d0_w < d1_w) ? 1'b0 : 1'(NP - 2)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sg_vld_r <= 1'b0;
    end else if (en) begin
      sg_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg_res_r  <= r_w;
      sg_zero_r <= d1_zero;
      sg_seg_r  <= seg_w;
    end
  end

  // ---------------------------------------------------------------------
  // log2 of both endpoint concentrations, Q16, one squaring of each per stage
  // ---------------------------------------------------------------------
  function automatic logic [4:0] msb17(input logic [PPM_W-1:0] p);
    logic [4:0] n;
    n = '0;
    for (int i = 1; i < PPM_W; i++) begin
      if (p[i]) n = 5'(i);
    end
    return n;
  endfunction

  logic [PPM_W-1:0] pi_w, pj_w, pi1_w, pj1_w;
  logic [4:0]       ni_w, nj_w;
  lg_t              lg_r   [0:16];
  logic             lgv_r  [0:16];

  assign pi_w  = sg_seg_r ? ppm_b_r : ppm_a_r;
  assign pj_w  = sg_seg_r ? ppm_c_r : ppm_b_r;
  assign pi1_w = (pi_w == '0) ? PPM_W'(1) : pi_w;   // zero ppm taken as one
  assign pj1_w = (pj_w == '0) ? PPM_W'(1) : pj_w;
  assign ni_w  = msb17(pi1_w);
  assign nj_w  = msb17(pj1_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lgv_r[0] <= 1'b0;
    end else if (en) begin
      lgv_r[0] <= sg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lg_r[0].xi   <= M_W'(pi1_w) << (5'd30 - ni_w);
      lg_r[0].xj   <= M_W'(pj1_w) << (5'd30 - nj_w);
      lg_r[0].li   <= {ni_w, 16'd0};
      lg_r[0].lj   <= {nj_w, 16'd0};
      lg_r[0].ri   <= sg_seg_r ? res_b_r : res_a_r;
      lg_r[0].rj   <= sg_seg_r ? res_c_r : res_b_r;
      lg_r[0].res  <= sg_res_r;
      lg_r[0].zero <= sg_zero_r;
    end
  end

  for (genvar s = 1; s <= 16; s++) begin : g_log
    logic [2*M_W-1:0] sqi, sqj;
    logic [31:0]      ti, tj;
    lg_t              nx;
    assign sqi = (2*M_W)'(lg_r[s-1].xi) * (2*M_W)'(lg_r[s-1].xi);
    assign sqj = (2*M_W)'(lg_r[s-1].xj) * (2*M_W)'(lg_r[s-1].xj);
    assign ti  = sqi[61:30];
    assign tj  = sqj[61:30];

    always_comb begin
      nx    = lg_r[s-1];
      nx.xi = ti[31] ? ti[31:1] : ti[30:0];
      nx.xj = tj[31] ? tj[31:1] : tj[30:0];
      if (ti[31]) nx.li = lg_r[s-1].li | (LOG_W'(1) << (16 - s));
      if (tj[31]) nx.lj = lg_r[s-1].lj | (LOG_W'(1) << (16 - s));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        lgv_r[s] <= 1'b0;
      end else if (en) begin
        lgv_r[s] <= lgv_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) lg_r[s] <= nx;
    end
  end

  // ---------------------------------------------------------------------
  // interpolation: (R - Ri)*(Lj - Li) / (Rj - Ri), sign-magnitude
  // ---------------------------------------------------------------------
  lg_t              lf;
  logic [RES_W-1:0] dr_mag, dd_mag;
  logic [LOG_W-1:0] dl_mag;
  logic [44:0]      num2_w;
  side2_t           s2_in, s2_out;
  logic             d2_vld, d2_sat;
  logic [21:0]      d2_q;

  assign lf     = lg_r[16];
  assign dr_mag = (lf.res >= lf.ri) ? (lf.res - lf.ri) : (lf.ri - lf.res);
  assign dl_mag = (lf.lj >= lf.li) ? (lf.lj - lf.li) : (lf.li - lf.lj);
  assign dd_mag = (lf.rj >= lf.ri) ? (lf.rj - lf.ri) : (lf.ri - lf.rj);
  assign num2_w = 45'(dr_mag) * 45'(dl_mag);

  always_comb begin
    s2_in.li   = lf.li;
    s2_in.neg  = (lf.res < lf.ri) ^ (lf.lj < lf.li) ^ (lf.rj < lf.ri);
    s2_in.flat = (lf.rj == lf.ri);
    s2_in.res  = lf.res;
    s2_in.zero = lf.zero;
  end

  // quotients of 2^22 and beyond push the exponent out of range either way
  glin_div #(.NW(45), .DW(RES_W), .QW(22), .SW(S2_W)) u_div_exp (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (lgv_r[16]),
    .num      (num2_w),
    .den      (dd_mag),
    .in_side  (s2_in),
    .out_vld  (d2_vld),
    .quo      (d2_q),
    .sat      (d2_sat),
    .out_side (s2_out)
  );

  // exponent and range split
  logic [22:0]        qm_w;
  logic signed [24:0] li_s, q_s, e_w, ee_w;
  ex_t                ex_r  [0:16];
  logic               exv_r [0:16];

  assign qm_w = d2_sat ? (23'd1 << 22) : {1'b0, d2_q};
  assign li_s = $signed({4'd0, s2_out.li});
  assign q_s  = $signed({2'd0, qm_w});
  assign e_w  = s2_out.flat ? li_s : (s2_out.neg ? (li_s - q_s) : (li_s + q_s));
  assign ee_w = e_w - E_LO;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exv_r[0] <= 1'b0;
    end else if (en) begin
      exv_r[0] <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r[0].m    <= M_W'(1) << 30;
      ex_r[0].f    <= ee_w[15:0];
      ex_r[0].npl9 <= ee_w[20:16];
      ex_r[0].hi   <= (e_w >= E_HI);
      ex_r[0].lo   <= (e_w < E_LO);
      ex_r[0].res  <= s2_out.res;
      ex_r[0].zero <= s2_out.zero;
    end
  end

  // 2^frac as a product of Q30 root factors, most significant bit first
  for (genvar s = 1; s <= 16; s++) begin : g_exp
    localparam logic [M_W-1:0] ROOT = exp_root(16 - s);
    logic [2*M_W-1:0] prod;
    ex_t              nx;
    assign prod = (2*M_W)'(ex_r[s-1].m) * (2*M_W)'(ROOT);

    always_comb begin
      nx = ex_r[s-1];
      if (ex_r[s-1].f[16 - s]) nx.m = prod[60:30];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        exv_r[s] <= 1'b0;
      end else if (en) begin
        exv_r[s] <= exv_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) ex_r[s] <= nx;
    end
  end

  // ---------------------------------------------------------------------
  // result register: scale to Q8, apply status rules
  // ---------------------------------------------------------------------
  ex_t              xf;
  logic [4:0]       sh_w;
  logic [24:0]      q8_w;
  logic             rng_w;
  logic [PPM_W-1:0] ppm_r, ppm_nxt;
  logic [RES_W-1:0] res_r, res_nxt;
  logic [ST_W-1:0]  st_r, st_nxt;

  assign xf    = ex_r[16];
  assign sh_w  = 5'd31 - xf.npl9;
  assign q8_w  = 25'(xf.m >> sh_w);
  assign rng_w = xf.hi || (!xf.lo && q8_w >= Q8_LIM);

  always_comb begin
    res_nxt = xf.res;
    ppm_nxt = '0;
    st_nxt  = ST_OK;
    if (xf.zero) begin
      res_nxt = RES_MAX;
      st_nxt  = ST_ZERO;
    end else if (rng_w) begin
      st_nxt = ST_RANGE;
    end else if (!xf.lo) begin
      ppm_nxt = q8_w[24:8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= exv_r[16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ppm_r <= ppm_nxt;
      res_r <= res_nxt;
      st_r  <= st_nxt;
    end
  end

  assign out_ch.valid              = out_vld_r;
  assign out_ch.concentration_ppm  = ppm_r;
  assign out_ch.resistance_kohm_q8 = res_r;
  assign out_ch.status             = st_r;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_zero_res: assert property (@(posedge clk) disable iff (!rst_n)
      out_vld_r && st_r == ST_ZERO |-> res_r == RES_MAX)
    else $error("zero-voltage result without saturated resistance");

  a_ppm_clear: assert property (@(posedge clk) disable iff (!rst_n)
      out_vld_r && st_r != ST_OK |-> ppm_r == '0)
    else $error("nonzero ppm on a failed transaction");

  a_ppm_span: assert property (@(posedge clk) disable iff (!rst_n)
      out_vld_r && st_r == ST_OK |-> ppm_r <= 17'd99999)
    else $error("ppm above limit with ok status");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
      !en |=> $stable(exv_r[16]) && $stable(lgv_r[16]))
    else $error("pipeline moved during a stall");

endmodule

// ----- dv/tb_gas_sensor_ppm_linearizer_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for gas_sensor_ppm_linearizer_top: directed table, then random
// voltages over several register settings, checked against a built-in ppm predictor.
// Depends on glin_pkg and the glin_in_if / glin_out_if interfaces.
module tb_gas_sensor_ppm_linearizer_top;
  import glin_pkg::*;

  localparam int SUPPLY     = 5000;
  localparam int LATENCY    = 86;
  localparam int IDLE_LIMIT = 20000;
  localparam int N_RANDOM   = 1750;

  typedef struct packed {
    logic [PPM_W-1:0] ppm;
    logic [RES_W-1:0] res;
    logic [ST_W-1:0]  st;
  } reading_t;

  // directed row: voltage, and optionally a typed-in expected reading
  typedef struct {
    int unsigned volts;
    bit          typed;
    reading_t    want;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  glin_in_if  in_ch();
  glin_out_if out_ch();

  gas_sensor_ppm_linearizer_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the register file for the predictor
  int unsigned gain_reg, load_reg;
  int unsigned res_pt[3];
  int unsigned ppm_pt[3];

  reading_t pending_readings[$];
  int       n_fail = 0;
  int       n_seen = 0;
  int       n_ok = 0, n_zero = 0, n_range = 0;
  int       idle_cycles = 0;
  bit       hold_off = 1'b0;

  function automatic longint unsigned sqrt64(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // log2 in Q16 by repeated squaring of a Q30 mantissa
  function automatic longint log2_fix(int unsigned v);
    int n;
    longint unsigned x;
    longint acc;
    n = 0;
    v &= 32'h1FFFF;
    if (v == 0) v = 1;
    while (n < 16 && (v >> (n + 1)) != 0) n++;
    x = longint'(v) << (30 - n);
    acc = longint'(n) * 65536;
    for (int k = 15; k >= 0; k--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x >>= 1;
        acc += longint'(1) << k;
      end
    end
    return acc;
  endfunction

  // 2^(e/65536) in Q8 from a product of Q30 root factors
  function automatic longint unsigned pow2_q8(longint e);
    longint unsigned ee, m, c;
    int n;
    int unsigned f;
    ee = longint'(e + 9 * 65536);
    n = int'(ee >> 16) - 9;
    f = 32'(ee & 16'hFFFF);
    m = 64'd1 << 30;
    c = 64'd2 << 30;
    for (int j = 15; j >= 0; j--) begin
      c = sqrt64(c << 30);
      if ((f >> j) & 1) m = (m * c) >> 30;
    end
    return m >> (22 - n);
  endfunction

  function automatic reading_t predict_reading(int unsigned volts);
    reading_t rd;
    longint unsigned g, l, load_ohm, gain_milli, top, r, q8;
    longint rr, ri, rj, li, lj, e, d0, d1, a, b;
    int seg;
    bit found;
    g = gain_reg;
    l = load_reg;
    if (g < 1) g = 1;
    if (g > 100) g = 100;
    if (l > 100) l = 100;
    load_ohm = ((128 * l + 99) / 100) * 781 + 120;
    gain_milli = 1120 + 781 * (((g - 1) * 128) / 100);
    if (volts == 0) begin
      rd.ppm = '0;
      rd.res = RES_MAX;
      rd.st = ST_ZERO;
      return rd;
    end
    top = SUPPLY * gain_milli;
    if (top <= 1000 * longint'(volts)) r = 0;
    else begin
      r = (load_ohm * (top - 1000 * volts) * 256) / (1000000 * longint'(volts));
      if (r > RES_MAX) r = RES_MAX;
    end
    rr = longint'(r);
    found = 1'b0;
    seg = 0;
    for (int i = 0; i < 2 && !found; i++) begin
      a = res_pt[i];
      b = res_pt[i + 1];
      if ((rr > a && rr <= b) || (rr <= a && rr > b)) begin
        found = 1'b1;
        seg = i;
      end
    end
    if (!found) begin
      d0 = rr - longint'(res_pt[0]);
      d1 = rr - longint'(res_pt[2]);
      if (d0 < 0) d0 = -d0;
      if (d1 < 0) d1 = -d1;
      seg = (d0 < d1) ? 0 : 1;
    end
    ri = res_pt[seg];
    rj = res_pt[seg + 1];
    li = log2_fix(ppm_pt[seg]);
    lj = log2_fix(ppm_pt[seg + 1]);
    e = li;
    if (rj != ri) e = li + ((rr - ri) * (lj - li)) / (rj - ri);
    rd.res = r[RES_W-1:0];
    rd.ppm = '0;
    rd.st = ST_RANGE;
    if (e >= 17 * 65536) return rd;
    q8 = (e < -9 * 65536) ? 0 : pow2_q8(e);
    if (q8 < 25599975) begin
      rd.ppm = (q8 >> 8) & 17'h1FFFF;
      rd.st = ST_OK;
    end
    return rd;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val[CFG_DW-1:0];
    case (idx)
      CFG_GAIN:  gain_reg = val & 32'h7F;
      CFG_LOAD:  load_reg = val & 32'h7F;
      CFG_RES_A: res_pt[0] = val & 32'hFFFFFF;
      CFG_RES_B: res_pt[1] = val & 32'hFFFFFF;
      CFG_RES_C: res_pt[2] = val & 32'hFFFFFF;
      CFG_PPM_A: ppm_pt[0] = val & 32'h1FFFF;
      CFG_PPM_B: ppm_pt[1] = val & 32'h1FFFF;
      default:   ppm_pt[2] = val & 32'h1FFFF;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // let every outstanding transaction drain before touching registers
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one transaction on the input channel, with random bursts and gaps;
  // valid stays high across a burst and drops only for a gap
  int burst_left = 0;
  task automatic send_sample(input int unsigned volts, input bit typed,
                             input reading_t want);
    reading_t exp_rd;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    exp_rd = predict_reading(volts);
    if (typed && exp_rd != want) begin
      $error("table row v=%0d disagrees with predictor", volts);
      n_fail++;
    end
    in_ch.valid <= 1'b1;
    in_ch.voltage_mv <= volts[V_W-1:0];
    do @(posedge clk); while (!in_ch.ready);
    pending_readings.push_back(typed ? want : exp_rd);
  endtask

  // receiver: own stall pattern, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (hold_off) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 7) > 2) || ($urandom_range(0, 99) < 20);
  end

  // result checker
  always @(posedge clk) begin
    reading_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.ppm = out_ch.concentration_ppm;
      got.res = out_ch.resistance_kohm_q8;
      got.st = out_ch.status;
      n_seen++;
      case (got.st)
        ST_OK:   n_ok++;
        ST_ZERO: n_zero++;
        default: n_range++;
      endcase
      if (pending_readings.size() == 0) begin
        $error("unexpected transaction on result channel");
        n_fail++;
      end else begin
        want = pending_readings.pop_front();
        if (got.ppm !== want.ppm) begin
          $error("concentration_ppm: expected %0d actual %0d", want.ppm, got.ppm);
          n_fail++;
        end
        if (got.res !== want.res) begin
          $error("resistance_kohm_q8: expected %0d actual %0d", want.res, got.res);
          n_fail++;
        end
        if (got.st !== want.st) begin
          $error("status: expected %0d actual %0d", want.st, got.st);
          n_fail++;
        end
      end
    end
  end

  // watchdog: cycles without any transaction on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // random voltage: mostly 0 to 5000 mV, weighted toward 0-20 mV and 4000-5000 mV
  function automatic int unsigned rand_volts();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 8191);
      1:       return $urandom_range(0, 20);
      2, 3:    return $urandom_range(4000, 5000);
      default: return $urandom_range(0, 5000);
    endcase
  endfunction

  vec_row_t vectors[$];

  initial begin
    reading_t none;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.voltage_mv = '0;
    // reset values mirrored locally
    gain_reg = 1;
    load_reg = 100;
    res_pt = '{29269, 10292, 3014};
    ppm_pt = '{50, 100, 300};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed table: zero voltage typed in; the rest predicted
    vectors = '{
      '{0, 1'b1, '{'0, RES_MAX, ST_ZERO}},
      '{5000, 1'b0, none}, '{5600, 1'b0, none},
      '{8191, 1'b0, none}, '{1, 1'b0, none}, '{2, 1'b0, none},
      '{1000, 1'b0, none}, '{2500, 1'b0, none}, '{4096, 1'b0, none},
      '{4500, 1'b0, none}, '{4900, 1'b0, none}, '{4990, 1'b0, none},
      '{100, 1'b0, none}, '{300, 1'b0, none}, '{1365, 1'b0, none},
      '{2730, 1'b0, none}, '{5460, 1'b0, none}, '{7000, 1'b0, none}
    };
    foreach (vectors[i]) send_sample(vectors[i].volts, vectors[i].typed, vectors[i].want);
    drain();

    // gain/load extremes, out-of-range codes, flat segment and zero ppm
    write_reg(CFG_GAIN, 0);
    write_reg(CFG_LOAD, 0);
    write_reg(CFG_PPM_A, 0);
    write_reg(CFG_RES_B, 29269);
    send_sample(2500, 1'b0, none);
    send_sample(6000, 1'b0, none);
    send_sample(1, 1'b0, none);
    drain();
    write_reg(CFG_GAIN, 127);
    write_reg(CFG_LOAD, 127);
    write_reg(CFG_PPM_C, 100000);
    write_reg(CFG_RES_C, 16777215);
    send_sample(1, 1'b0, none);
    send_sample(8191, 1'b0, none);
    send_sample(100, 1'b0, none);
    drain();

    // random phases: the first keeps the current registers, later ones get fresh random registers, one an extreme set
    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 3) begin
        write_reg(CFG_GAIN, 100);
        write_reg(CFG_LOAD, 1);
        write_reg(CFG_RES_A, 1);
        write_reg(CFG_RES_B, 16777215);
        write_reg(CFG_RES_C, 8388608);
        write_reg(CFG_PPM_A, 1);
        write_reg(CFG_PPM_B, 131071);
        write_reg(CFG_PPM_C, 65536);
      end else if (ph > 0) begin
        write_reg(CFG_GAIN, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(1, 100));
        write_reg(CFG_LOAD, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                       : $urandom_range(1, 100));
        for (int k = 0; k < 3; k++)
          write_reg(CFG_IDX_W'(CFG_RES_A + k),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 24'hFFFFFF)
                                                : $urandom_range(500, 60000));
        for (int k = 0; k < 3; k++)
          write_reg(CFG_IDX_W'(CFG_PPM_A + k),
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071)
                                                : $urandom_range(1, 2000));
      end
      // long receiver hold-off while samples keep coming in the second phase
      if (ph == 1) fork
        begin
          hold_off = 1'b1;
          repeat (300) @(posedge clk);
          hold_off = 1'b0;
        end
      join_none
      for (int n = 0; n < N_RANDOM / 7; n++) send_sample(rand_volts(), 1'b0, none);
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    $display("Run covered %0d results (ok %0d, zero voltage %0d, out of range %0d)",
             n_seen, n_ok, n_zero, n_range);
    $display("over directed extremes and seven register settings.");
    if (n_fail == 0 && pending_readings.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/glin_pkg.sv
hw/rtl/glin_if.sv
hw/rtl/glin_div.sv
hw/rtl/gas_sensor_ppm_linearizer_top.sv
dv/tb_gas_sensor_ppm_linearizer_top.sv
